// File: rtl/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg
// shared types and constants of the ascii85 line encoder
// ----------------------------------------------------------------------------
package a85_pkg;

   localparam int unsigned A85_DIGITS       = 5;
   localparam int unsigned A85_DIGIT_W      = 7;
   localparam int unsigned A85_QUEUE_DEPTH  = 2;

   localparam logic [7:0]  A85_OFFSET       = 8'd33;
   localparam logic [7:0]  A85_ZERO_CHAR    = 8'd122;
   localparam logic [7:0]  A85_NEWLINE      = 8'd10;
   localparam logic [7:0]  A85_ROW_MIN      = 8'd5;
   localparam logic [7:0]  A85_ROW_RESET    = 8'd72;

   // reciprocal of 85 for 32-bit operands, quotient = (w * recip) >> shift
   localparam logic [31:0] A85_RECIP        = 32'hC0C0C0C1;
   localparam int unsigned A85_RECIP_SHIFT  = 38;
   localparam int unsigned A85_QUOT_W       = 64 - A85_RECIP_SHIFT;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       flush;
   } a85_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } a85_rsp_type;

   // one encoded group or line end, handed from front to back
   typedef struct packed {
      logic [A85_DIGITS-1:0][A85_DIGIT_W-1:0] digits;
      logic [2:0]                             count;
      logic                                   zero_char;
      logic                                   flush;
   } a85_job_type;

endpackage

// File: rtl/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front
// collects request bytes into groups and converts each group to base-85 digits
// ----------------------------------------------------------------------------
module a85_front
   import a85_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  a85_req_type req_data,
   output logic        q_push,
   input  logic        q_full,
   output a85_job_type q_data
);

   typedef enum logic [2:0] {
      CONV_IDLE = 3'b001,
      CONV_RUN  = 3'b010,
      CONV_PUSH = 3'b100
   } a85_conv_state_type;

   a85_conv_state_type state_ff, state_in;
   logic [23:0]        group_ff, group_in;
   logic [1:0]         count_ff, count_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [31:0]        hold_word_ff, hold_word_in;
   a85_job_type        hold_job_ff, hold_job_in;
   logic [31:0]        word_ff, word_in;
   a85_job_type        job_ff, job_in;
   logic [2:0]         step_ff, step_in;

   logic                  accept;
   logic                  take;
   logic [31:0]           full_word;
   logic [63:0]           product;
   logic [A85_QUOT_W-1:0] quot;
   logic [31:0]           quot_w;
   logic [31:0]           quot_x85;
   logic [31:0]           rem_w;

   assign full   = hold_valid_ff;
   assign accept = push && !hold_valid_ff;
   assign take   = (state_ff == CONV_IDLE) && hold_valid_ff;
   assign q_push = (state_ff == CONV_PUSH) && !q_full;
   assign q_data = job_ff;

   assign full_word = {group_ff, req_data.data_byte};

   // divide by 85 through the reciprocal
   assign product  = {32'b0, word_ff} * {32'b0, A85_RECIP};
   assign quot     = product[63:A85_RECIP_SHIFT];
   assign quot_w   = 32'(quot);
   assign quot_x85 = (quot_w << 6) + (quot_w << 4) + (quot_w << 2) + quot_w;
   assign rem_w    = word_ff - quot_x85;

   always_comb begin
      group_in      = group_ff;
      count_in      = count_ff;
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      hold_job_in   = hold_job_ff;
      state_in      = state_ff;
      word_in       = word_ff;
      job_in        = job_ff;
      step_in       = step_ff;

      if (take) begin
         hold_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_data.flush) begin
            case (count_ff)
               2'd1: hold_word_in = {group_ff[7:0], 24'b0};
               2'd2: hold_word_in = {group_ff[15:0], 16'b0};
               2'd3: hold_word_in = {group_ff, 8'b0};
               default: hold_word_in = '0;
            endcase
            hold_job_in.digits    = '0;
            hold_job_in.count     = (count_ff == 2'd0) ? 3'd0 : {1'b0, count_ff} + 3'd1;
            hold_job_in.zero_char = 1'b0;
            hold_job_in.flush     = 1'b1;
            hold_valid_in         = 1'b1;
            group_in              = '0;
            count_in              = '0;
         end else if (count_ff != 2'd3) begin
            group_in = {group_ff[15:0], req_data.data_byte};
            count_in = count_ff + 2'd1;
         end else begin
            hold_word_in          = full_word;
            hold_job_in.digits    = '0;
            hold_job_in.zero_char = (full_word == 32'd0);
            hold_job_in.count     = (full_word == 32'd0) ? 3'd1 : 3'(A85_DIGITS);
            hold_job_in.flush     = 1'b0;
            hold_valid_in         = 1'b1;
            group_in              = '0;
            count_in              = '0;
         end
      end

      case (state_ff)
         CONV_IDLE: begin
            if (take) begin
               word_in = hold_word_ff;
               job_in  = hold_job_ff;
               step_in = 3'(A85_DIGITS - 1);
               if (hold_job_ff.zero_char || hold_job_ff.count == 3'd0) begin
                  state_in = CONV_PUSH;
               end else begin
                  state_in = CONV_RUN;
               end
            end
         end
         CONV_RUN: begin
            word_in                 = quot_w;
            job_in.digits[step_ff]  = rem_w[A85_DIGIT_W-1:0];
            if (step_ff == 3'd0) begin
               state_in = CONV_PUSH;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         CONV_PUSH: begin
            if (!q_full) begin
               state_in = CONV_IDLE;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CONV_IDLE;
         group_ff      <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         group_ff      <= group_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_word_ff <= hold_word_in;
      hold_job_ff  <= hold_job_in;
      word_ff      <= word_in;
      job_ff       <= job_in;
      step_ff      <= step_in;
   end

`ifndef ASSERT_OFF
   // an idle converter picks up a waiting group at once
   a_hold_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV_IDLE && hold_valid_ff) |=> !hold_valid_ff)
      else $error("waiting group not taken by idle converter");
`endif

endmodule

// File: rtl/a85_queue.sv
// ----------------------------------------------------------------------------
// a85_queue
// short queue of encoded groups between front and back
// ----------------------------------------------------------------------------
module a85_queue
   import a85_pkg::*;
#(
   parameter int unsigned DEPTH = A85_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   output logic        wr_full,
   input  a85_job_type wr_data,
   output logic        rd_valid,
   input  logic        rd_en,
   output a85_job_type rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   a85_job_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_wr, do_rd;

   assign wr_full  = (fill_ff == CNT_W'(DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !wr_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   // pointers and fill level agree
   a_fill_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill level");
`endif

endmodule

// File: rtl/a85_back.sv
// ----------------------------------------------------------------------------
// a85_back
// emits characters of each group, inserts line breaks, holds the row length
// ----------------------------------------------------------------------------
module a85_back
   import a85_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        q_valid,
   output logic        q_pop,
   input  a85_job_type q_head,
   output logic        empty,
   input  logic        pop,
   output a85_rsp_type rsp_data
);

   logic [7:0]  row_ff, row_in;
   logic [7:0]  column_ff, column_in;
   logic        nl_ff, nl_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   a85_rsp_type rsp_ff, rsp_in;

   logic                   advance;
   logic [7:0]             limit;
   logic [7:0]             col_inc;
   logic [A85_DIGIT_W-1:0] digit_sel;
   logic [7:0]             digit_char;
   logic                   emit;
   logic                   done;
   logic [7:0]             ch;
   logic                   lst;

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign advance  = !rsp_valid_ff || pop;
   assign limit    = (row_ff < A85_ROW_MIN) ? A85_ROW_MIN : row_ff;
   assign col_inc  = column_ff + 8'd1;

   always_comb begin
      case (idx_ff)
         3'd0: digit_sel = q_head.digits[0];
         3'd1: digit_sel = q_head.digits[1];
         3'd2: digit_sel = q_head.digits[2];
         3'd3: digit_sel = q_head.digits[3];
         3'd4: digit_sel = q_head.digits[4];
         default: digit_sel = '0;
      endcase
   end

   assign digit_char = {1'b0, digit_sel} + A85_OFFSET;

   always_comb begin
      row_in       = csr_we ? csr_wdata : row_ff;
      column_in    = column_ff;
      nl_in        = nl_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      emit         = 1'b0;
      done         = 1'b0;
      ch           = A85_NEWLINE;
      lst          = 1'b0;

      if (advance && q_valid) begin
         if (nl_ff) begin
            // line break after a full row
            emit  = 1'b1;
            nl_in = 1'b0;
            lst   = (idx_ff == q_head.count);
            done  = lst;
         end else if (idx_ff < q_head.count) begin
            emit   = 1'b1;
            ch     = q_head.zero_char ? A85_ZERO_CHAR : digit_char;
            idx_in = idx_ff + 3'd1;
            if (col_inc >= limit) begin
               column_in = '0;
               nl_in     = 1'b1;
            end else begin
               column_in = col_inc;
               lst       = (idx_in == q_head.count) && !(q_head.flush && col_inc != 8'd0);
               done      = lst;
            end
         end else begin
            // line end on flush, or nothing at all
            if (q_head.flush && column_ff != 8'd0) begin
               emit      = 1'b1;
               lst       = 1'b1;
               column_in = '0;
            end
            done = 1'b1;
         end
      end

      if (done) begin
         idx_in = '0;
      end

      if (advance) begin
         rsp_valid_in    = emit;
         rsp_in.out_char = ch;
         rsp_in.last     = lst;
      end
   end

   assign q_pop = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= A85_ROW_RESET;
         column_ff    <= '0;
         nl_ff        <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         column_ff    <= column_in;
         nl_ff        <= nl_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   // a pending line break follows a character that cleared the column
   a_nl_column: assert property (@(posedge clock) disable iff (reset)
      nl_ff |-> (column_ff == 8'd0))
      else $error("line break pending with nonzero column");

   // a pending line break always sits behind a character in the output register
   a_nl_behind_char: assert property (@(posedge clock) disable iff (reset)
      nl_ff |-> rsp_valid_ff)
      else $error("line break pending without a character ahead of it");

   // groups leave the queue only once present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");
`endif

endmodule

// File: rtl/ascii85_line_encoder_top.sv
// ----------------------------------------------------------------------------
// ascii85_line_encoder_top
// streaming ascii85 encoder with line breaking
// ----------------------------------------------------------------------------
// Each request carries a byte or a flush. Four bytes form a big-endian group
// that comes out as five characters '!'..'u', or 'z' for an all-zero group;
// a flush pads a partial group and ends a nonempty line with a newline. A
// newline follows every row_length characters (values below 5 act as 5);
// write row_length only while the encoder is idle. Requests are taken one
// per cycle while the front collects a group and the holding register is empty;
// a completed group or a flush waits in that one-entry holding register until
// the base-85 converter is free, and the converter makes one digit per cycle
// through a reciprocal multiply, stepping through idle, run and push states.
// Results leave at one character per cycle from the output register while the
// consumer pops, and the front collects the next group while one converts.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ascii85_line_encoder_top
   import a85_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = A85_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  a85_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output a85_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic        q_push;
   logic        q_full;
   a85_job_type q_wdata;
   logic        q_valid;
   logic        q_pop;
   a85_job_type q_head;

   a85_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wdata)
   );

   a85_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_full  (q_full),
      .wr_data  (q_wdata),
      .rd_valid (q_valid),
      .rd_en    (q_pop),
      .rd_data  (q_head)
   );

   a85_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
